// File: src/rpe_pkg.sv
// Shared constants, types and the arctangent table for the rotary pair embedding datapath.
`default_nettype none
package rpe_pkg;

    localparam int ANGLE_WIDTH    = 32;
    localparam int PHASE_WIDTH    = 32;
    localparam int PRODUCT_WIDTH  = 64;
    localparam int PHASE_LSB      = 30;
    localparam int GUARD          = 16;
    localparam int GAIN_WIDTH     = 31;
    localparam int GAIN_SHIFT     = 31 - GUARD;
    localparam int MAX_STAGES     = 32;
    localparam int TURNS_WIDTH    = 42;
    localparam int K_SPLIT        = 21;
    localparam int PART_WIDTH     = ANGLE_WIDTH + K_SPLIT + 1;

    localparam logic [TURNS_WIDTH-1:0] TURNS_PER_RAD = 42'h28B_E60D_B939;
    localparam logic [GAIN_WIDTH-1:0]  GAIN_INV      = 31'd1304065748;
    localparam logic [PHASE_WIDTH-1:0] EIGHTH_TURN   = 32'h2000_0000;

    localparam logic [1:0] QTR_0 = 2'd0;
    localparam logic [1:0] QTR_1 = 2'd1;
    localparam logic [1:0] QTR_2 = 2'd2;
    localparam logic [1:0] QTR_3 = 2'd3;

    typedef logic [PHASE_WIDTH-1:0]        phase_t;
    typedef logic signed [PHASE_WIDTH-1:0] resid_t;
    typedef logic signed [ANGLE_WIDTH-1:0] angle_t;

    function automatic phase_t atan_turns(input logic [4:0] idx);
        phase_t r;
        case (idx)
            5'd0:    r = 32'h2000_0000;
            5'd1:    r = 32'h12E4_051D;
            5'd2:    r = 32'h09FB_385B;
            5'd3:    r = 32'h0511_11D4;
            5'd4:    r = 32'h028B_0D43;
            5'd5:    r = 32'h0145_D7E1;
            5'd6:    r = 32'h00A2_F61E;
            5'd7:    r = 32'h0051_7C55;
            5'd8:    r = 32'h0028_BE53;
            5'd9:    r = 32'h0014_5F2E;
            5'd10:   r = 32'h000A_2F98;
            5'd11:   r = 32'h0005_17CC;
            5'd12:   r = 32'h0002_8BE6;
            5'd13:   r = 32'h0001_45F3;
            5'd14:   r = 32'h0000_A2F9;
            5'd15:   r = 32'h0000_517C;
            5'd16:   r = 32'h0000_28BE;
            5'd17:   r = 32'h0000_145F;
            5'd18:   r = 32'h0000_0A2F;
            5'd19:   r = 32'h0000_0517;
            5'd20:   r = 32'h0000_028B;
            5'd21:   r = 32'h0000_0145;
            5'd22:   r = 32'h0000_00A2;
            5'd23:   r = 32'h0000_0051;
            5'd24:   r = 32'h0000_0028;
            5'd25:   r = 32'h0000_0014;
            5'd26:   r = 32'h0000_000A;
            5'd27:   r = 32'h0000_0005;
            5'd28:   r = 32'h0000_0002;
            5'd29:   r = 32'h0000_0001;
            default: r = 32'h0000_0000;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// File: src/rotary_pair_embedding.sv
// Pipeline: two front stages, one stage per CORDIC step, one output stage.
// Throughput: one pair per cycle while m_axis_tready stays high.
// Every stage holds its request while the next one is full, so stalls drop nothing.
// Reset (aresetn low, synchronous) clears the stage valid bits only, not the data registers.
`default_nettype none
module rotary_pair_embedding #(
    parameter int VALUE_WIDTH     = 16,
    parameter int ROTATION_STAGES = 16
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_axis_tvalid,
    output logic      s_axis_tready,
    // even_value, odd_value, angle (from bit 0 up), zero padded to bytes
    input  wire logic [((2*VALUE_WIDTH+rpe_pkg::ANGLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic      m_axis_tvalid,
    input  wire logic m_axis_tready,
    // rotated_even, rotated_odd (from bit 0 up), zero padded to bytes
    output logic [((2*VALUE_WIDTH+7)/8)*8-1:0] m_axis_tdata
);
    import rpe_pkg::*;

    localparam int XW     = VALUE_WIDTH + GUARD + 2;
    localparam int OUT_TW = ((2*VALUE_WIDTH + 7) / 8) * 8;
    localparam int NS     = (ROTATION_STAGES < MAX_STAGES) ? ROTATION_STAGES : MAX_STAGES;

    logic signed [VALUE_WIDTH-1:0] even_value, odd_value;
    angle_t                        angle;

    logic                 pv  [0:NS];
    logic                 pr  [0:NS];
    logic signed [XW-1:0] px  [0:NS];
    logic signed [XW-1:0] py  [0:NS];
    resid_t               pz  [0:NS];

    assign even_value = s_axis_tdata[VALUE_WIDTH-1:0];
    assign odd_value  = s_axis_tdata[2*VALUE_WIDTH-1:VALUE_WIDTH];
    assign angle      = s_axis_tdata[2*VALUE_WIDTH +: ANGLE_WIDTH];

    rpe_reduce #(
        .VALUE_WIDTH(VALUE_WIDTH),
        .XW         (XW)
    ) u_reduce (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .even_value(even_value),
        .odd_value (odd_value),
        .angle     (angle),
        .out_valid (pv[0]),
        .out_ready (pr[0]),
        .x_out     (px[0]),
        .y_out     (py[0]),
        .z_out     (pz[0])
    );

    for (genvar i = 0; i < NS; i++) begin : g_cordic
        rpe_cordic_stage #(
            .XW         (XW),
            .STAGE_INDEX(i)
        ) u_stage (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .in_valid (pv[i]),
            .in_ready (pr[i]),
            .x_in     (px[i]),
            .y_in     (py[i]),
            .z_in     (pz[i]),
            .out_valid(pv[i+1]),
            .out_ready(pr[i+1]),
            .x_out    (px[i+1]),
            .y_out    (py[i+1]),
            .z_out    (pz[i+1])
        );
    end

    rpe_output #(
        .VALUE_WIDTH(VALUE_WIDTH),
        .XW         (XW),
        .OUT_TW     (OUT_TW)
    ) u_output (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (pv[NS]),
        .in_ready     (pr[NS]),
        .x_in         (px[NS]),
        .y_in         (py[NS]),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

endmodule
`default_nettype wire

// File: src/rpe_reduce.sv
// Front end: angle to turn phase, gain scaling and quarter-turn pre-rotation, two stages.
`default_nettype none
module rpe_reduce #(
    parameter int VALUE_WIDTH = 16,
    parameter int XW          = 34
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [VALUE_WIDTH-1:0] even_value,
    input  wire logic signed [VALUE_WIDTH-1:0] odd_value,
    input  wire rpe_pkg::angle_t               angle,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [XW-1:0]               x_out,
    output logic signed [XW-1:0]               y_out,
    output rpe_pkg::resid_t                    z_out
);
    import rpe_pkg::*;

    localparam int GW = VALUE_WIDTH + 32;

    logic                         a_valid_reg, a_valid_next;
    logic                         a_ready;
    logic signed [PART_WIDTH-1:0] p_lo_reg, p_hi_reg;
    logic signed [GW-1:0]         gx_reg, gy_reg;

    logic                         b_valid_reg, b_valid_next;
    logic signed [XW-1:0]         x_reg, x_next, y_reg, y_next;
    resid_t                       z_reg, z_next;

    logic signed [PRODUCT_WIDTH-1:0] full;
    phase_t                          phase, shifted;
    logic [1:0]                      quarter;
    logic signed [GW-1:0]            gx_sh, gy_sh;
    logic signed [XW-1:0]            x0, y0;

    assign in_ready     = !a_valid_reg || a_ready;
    assign a_ready      = !b_valid_reg || out_ready;
    assign a_valid_next = in_ready ? in_valid : a_valid_reg;
    assign b_valid_next = a_ready ? a_valid_reg : b_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            p_lo_reg <= angle * $signed({1'b0, TURNS_PER_RAD[K_SPLIT-1:0]});
            p_hi_reg <= angle * $signed({1'b0, TURNS_PER_RAD[TURNS_WIDTH-1:K_SPLIT]});
            gx_reg   <= even_value * $signed({1'b0, GAIN_INV});
            gy_reg   <= odd_value * $signed({1'b0, GAIN_INV});
        end
    end

    always_comb begin
        full    = (PRODUCT_WIDTH'(p_hi_reg) <<< K_SPLIT) + PRODUCT_WIDTH'(p_lo_reg);
        phase   = full[PHASE_LSB +: PHASE_WIDTH];
        shifted = phase + EIGHTH_TURN;
        quarter = shifted[PHASE_WIDTH-1 -: 2];
        z_next  = $signed({2'b00, shifted[PHASE_WIDTH-3:0]}) - $signed(EIGHTH_TURN);
        gx_sh   = gx_reg >>> GAIN_SHIFT;
        gy_sh   = gy_reg >>> GAIN_SHIFT;
        x0      = gx_sh[XW-1:0];
        y0      = gy_sh[XW-1:0];
        case (quarter)
            QTR_1: begin
                x_next = -y0;
                y_next = x0;
            end
            QTR_2: begin
                x_next = -x0;
                y_next = -y0;
            end
            QTR_3: begin
                x_next = y0;
                y_next = -x0;
            end
            default: begin
                x_next = x0;
                y_next = y0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (a_ready && a_valid_reg) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        a_valid_reg && !a_ready |=> a_valid_reg && $stable(p_lo_reg) && $stable(gx_reg))
        else $error("front stage lost a request under stall");

    b_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        b_valid_reg && !out_ready |=> b_valid_reg && $stable(z_reg) && $stable(x_reg))
        else $error("rotation stage lost a request under stall");

    resid_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        b_valid_reg |-> z_reg[PHASE_WIDTH-1 -: 3] == 3'b000 || z_reg[PHASE_WIDTH-1 -: 3] == 3'b111)
        else $error("residual angle outside one eighth turn");

endmodule
`default_nettype wire

// File: src/rpe_cordic_stage.sv
// One registered CORDIC micro-rotation step.
`default_nettype none
module rpe_cordic_stage #(
    parameter int XW          = 34,
    parameter int STAGE_INDEX = 0
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic signed [XW-1:0] x_in,
    input  wire logic signed [XW-1:0] y_in,
    input  wire rpe_pkg::resid_t      z_in,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic signed [XW-1:0]      x_out,
    output logic signed [XW-1:0]      y_out,
    output rpe_pkg::resid_t           z_out
);
    import rpe_pkg::*;

    logic                 valid_reg, valid_next;
    logic signed [XW-1:0] x_reg, x_next, y_reg, y_next;
    resid_t               z_reg, z_next;
    logic signed [XW-1:0] dx, dy;
    resid_t               step;

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_comb begin
        dx   = y_in >>> STAGE_INDEX;
        dy   = x_in >>> STAGE_INDEX;
        step = $signed(atan_turns(5'(STAGE_INDEX)));
        if (!z_in[PHASE_WIDTH-1]) begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - step;
        end else begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + step;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign out_valid = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;

endmodule
`default_nettype wire

// File: src/rpe_output.sv
// Round, saturate and hold the rotated pair in the output register.
`default_nettype none
module rpe_output #(
    parameter int VALUE_WIDTH = 16,
    parameter int XW          = 34,
    parameter int OUT_TW      = 32
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic signed [XW-1:0] x_in,
    input  wire logic signed [XW-1:0] y_in,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [OUT_TW-1:0]         m_axis_tdata
);
    import rpe_pkg::*;

    localparam int RW = XW - GUARD;
    localparam logic signed [XW-1:0] HALF = XW'(1) <<< (GUARD - 1);
    localparam logic signed [RW-1:0] VMAX = RW'((1 <<< (VALUE_WIDTH - 1)) - 1);
    localparam logic signed [RW-1:0] VMIN = -VMAX - RW'(1);

    logic                          valid_reg, valid_next;
    logic signed [VALUE_WIDTH-1:0] even_reg, even_next, odd_reg, odd_next;
    logic signed [XW-1:0]          xs, ys;
    logic signed [RW-1:0]          xr, yr;

    function automatic logic signed [VALUE_WIDTH-1:0] clip(input logic signed [RW-1:0] v);
        logic signed [VALUE_WIDTH-1:0] r;
        if (v > VMAX) begin
            r = VMAX[VALUE_WIDTH-1:0];
        end else if (v < VMIN) begin
            r = VMIN[VALUE_WIDTH-1:0];
        end else begin
            r = v[VALUE_WIDTH-1:0];
        end
        return r;
    endfunction

    assign in_ready   = !valid_reg || m_axis_tready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_comb begin
        xs        = (x_in + HALF) >>> GUARD;
        ys        = (y_in + HALF) >>> GUARD;
        xr        = xs[RW-1:0];
        yr        = ys[RW-1:0];
        even_next = clip(xr);
        odd_next  = clip(yr);
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            even_reg <= even_next;
            odd_reg  <= odd_next;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = OUT_TW'({odd_reg, even_reg});

endmodule
`default_nettype wire

// File: sim/tb_top.sv
// Streaming testbench for rotary_pair_embedding with a bit-exact rotation predictor.
`timescale 1ns / 1ps
module tb_top;

    localparam int  RANDOM_PAIRS = 650;
    localparam int  STAGES       = 16;
    localparam int  GUARD_BITS   = 16;
    localparam int  IDLE_PCT     = 18;
    localparam int  PI_Q18       = 823550;
    localparam int  HALF_PI_Q18  = 411775;
    localparam int  QTR_PI_Q18   = 205887;
    localparam int  TWO_PI_Q18   = 1647099;
    localparam longint GAIN_Q31  = 64'sd1304065748;
    localparam logic [63:0] TURNS_PER_RAD_Q44 = 64'h0000_028B_E60D_B939;

    typedef struct {
        logic signed [15:0] even_val;
        logic signed [15:0] odd_val;
        rpe_pkg::angle_t    angle;
        bit                 wait_drain;
    } pair_t;

    typedef struct {
        logic signed [15:0] rot_even;
        logic signed [15:0] rot_odd;
    } rot_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // even_value, odd_value, angle (from bit 0 up)
    logic [63:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // rotated_even, rotated_odd (from bit 0 up)
    logic [31:0] m_axis_tdata;

    pair_t pair_q[$];
    rot_t  rotated_q[$];
    bit    in_taken = 1'b0;
    int    pairs_sent = 0;
    int    results_seen = 0;
    int    sat_seen = 0;
    int    mismatch_cnt = 0;
    int    quadrant_hits[4] = '{0, 0, 0, 0};
    bit    idle_send;
    pair_t next_pair;
    rot_t  want;

    logic [31:0] atan_step [0:STAGES-1] = '{
        32'h2000_0000, 32'h12E4_051D, 32'h09FB_385B, 32'h0511_11D4,
        32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
        32'h0028_BE53, 32'h0014_5F2E, 32'h000A_2F98, 32'h0005_17CC,
        32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2F9, 32'h0000_517C
    };

    rotary_pair_embedding dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic logic signed [15:0] round_sat(input longint v);
        longint r;
        r = (v + (64'sd1 <<< (GUARD_BITS - 1))) >>> GUARD_BITS;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[15:0];
    endfunction

    function automatic rot_t rotate_pair(input logic signed [15:0] ev,
                                         input logic signed [15:0] od,
                                         input rpe_pkg::angle_t ang);
        logic [63:0] prod;
        logic [31:0] phase;
        logic [31:0] biased;
        logic [1:0]  qtr;
        longint      x;
        longint      y;
        longint      z;
        longint      t;
        longint      dx;
        longint      dy;
        rot_t        r;
        prod   = {{32{ang[31]}}, ang} * TURNS_PER_RAD_Q44;
        phase  = prod[61:30];
        biased = phase + 32'h2000_0000;
        qtr    = biased[31:30];
        z      = longint'(biased[29:0]) - 64'sd536870912;
        x      = (longint'(ev) * GAIN_Q31) >>> 15;
        y      = (longint'(od) * GAIN_Q31) >>> 15;
        case (qtr)
            rpe_pkg::QTR_1: begin
                t = x; x = -y; y = t;
            end
            rpe_pkg::QTR_2: begin
                x = -x; y = -y;
            end
            rpe_pkg::QTR_3: begin
                t = x; x = y; y = -t;
            end
            default: begin
            end
        endcase
        for (int i = 0; i < STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(atan_step[i]);
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(atan_step[i]);
            end
        end
        r.rot_even = round_sat(x);
        r.rot_odd  = round_sat(y);
        return r;
    endfunction

    function automatic int quadrant_of(input rpe_pkg::angle_t ang);
        logic [63:0] prod;
        logic [31:0] biased;
        prod   = {{32{ang[31]}}, ang} * TURNS_PER_RAD_Q44;
        biased = prod[61:30] + 32'h2000_0000;
        return int'(biased[31:30]);
    endfunction

    task automatic add_pair(input int ev, input int od, input int ang, input bit drain);
        pair_t p;
        p.even_val   = ev[15:0];
        p.odd_val    = od[15:0];
        p.angle      = ang;
        p.wait_drain = drain;
        pair_q.insert(pair_q.size(), p);
    endtask

    // sender: advance on accepted request, idle at random outside the quiet window
    always @(negedge aclk) begin
        idle_send = (pairs_sent < 250 || pairs_sent >= 400)
                    && ($urandom_range(99) < IDLE_PCT);
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_taken) begin
            if (pair_q.size() != 0 && !idle_send
                && (!pair_q[0].wait_drain || rotated_q.size() == 0)) begin
                next_pair = pair_q.pop_front();
                s_axis_tdata  <= {next_pair.angle, next_pair.odd_val, next_pair.even_val};
                s_axis_tvalid <= 1'b1;
                pairs_sent++;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        m_axis_tready <= (pairs_sent >= 250 && pairs_sent < 400)
                         || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge aclk) begin
        in_taken = aresetn && s_axis_tvalid && s_axis_tready;
        if (in_taken) begin
            rotated_q.insert(rotated_q.size(),
                             rotate_pair(s_axis_tdata[15:0], s_axis_tdata[31:16],
                                         s_axis_tdata[63:32]));
            quadrant_hits[quadrant_of(s_axis_tdata[63:32])]++;
        end
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (m_axis_tdata[15:0] == 16'h7FFF || m_axis_tdata[15:0] == 16'h8000
                || m_axis_tdata[31:16] == 16'h7FFF || m_axis_tdata[31:16] == 16'h8000) begin
                sat_seen++;
            end
            if (rotated_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10) begin
                    $display("unexpected result %h with no request pending", m_axis_tdata);
                end
            end else begin
                want = rotated_q.pop_front();
                if (m_axis_tdata[15:0] !== want.rot_even
                    || m_axis_tdata[31:16] !== want.rot_odd) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) begin
                        $display("result %0d: expected even %0d odd %0d, got even %0d odd %0d",
                                 results_seen, want.rot_even, want.rot_odd,
                                 $signed(m_axis_tdata[15:0]), $signed(m_axis_tdata[31:16]));
                    end
                end
            end
        end
    end

    initial begin
        int kind;
        int ev;
        int od;
        int ang;
        int extremes[4];
        extremes = '{-32768, 32767, -32767, 0};

        add_pair(32767, 0, 0, 1'b0);
        add_pair(-32768, 0, 0, 1'b0);
        add_pair(0, 32767, 0, 1'b0);
        add_pair(0, -32768, 0, 1'b0);
        add_pair(32767, 32767, 0, 1'b0);
        add_pair(16384, -8192, HALF_PI_Q18, 1'b0);
        add_pair(16384, -8192, PI_Q18, 1'b0);
        add_pair(16384, -8192, -HALF_PI_Q18, 1'b0);
        add_pair(16384, -8192, 3 * HALF_PI_Q18, 1'b0);
        add_pair(16384, -8192, TWO_PI_Q18, 1'b0);
        add_pair(-32768, -32768, QTR_PI_Q18, 1'b0);
        add_pair(32767, 32767, QTR_PI_Q18, 1'b0);
        add_pair(32767, -32768, -QTR_PI_Q18, 1'b0);
        add_pair(-32768, 32767, 3 * QTR_PI_Q18, 1'b0);
        add_pair(20000, 20000, QTR_PI_Q18 + 1, 1'b0);
        add_pair(12345, -23456, 32'h7FFF_FFFF, 1'b0);
        add_pair(12345, -23456, 32'h8000_0000, 1'b0);
        add_pair(-1, 1, 32'hFFFF_FFFF, 1'b0);
        add_pair(1, -1, 1, 1'b0);
        add_pair(32767, -32768, 32'h5555_5555, 1'b0);
        add_pair(0, 0, 32'hAAAA_AAAA, 1'b0);

        for (int n = 0; n < RANDOM_PAIRS; n++) begin
            kind = $urandom_range(99);
            ev   = int'($signed(16'($urandom)));
            od   = int'($signed(16'($urandom)));
            if (kind < 55) begin
                ang = int'($urandom_range(2 * TWO_PI_Q18)) - TWO_PI_Q18;
            end else if (kind < 80) begin
                ang = $urandom;
            end else begin
                ev  = extremes[$urandom_range(3)];
                od  = extremes[$urandom_range(3)];
                ang = int'($urandom_range(2 * TWO_PI_Q18)) - TWO_PI_Q18;
            end
            add_pair(ev, od, ang, n == 0 || n == 120 || n == 480);
        end

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (pair_q.size() != 0 || s_axis_tvalid) @(posedge aclk);
        while (rotated_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);

        $display("Rotated %0d pairs, checked %0d results, %0d with a clipped output.",
                 pairs_sent, results_seen, sat_seen);
        $display("Angles per quarter turn: %0d / %0d / %0d / %0d; %0d mismatches.",
                 quadrant_hits[0], quadrant_hits[1], quadrant_hits[2], quadrant_hits[3],
                 mismatch_cnt);
        if (mismatch_cnt == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d results outstanding", rotated_q.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule
